// ===== rtl/spmd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the signal pending mask dispatch block.
// Holds operation and action codes, signal numbers and the default-action table.
// No dependencies.
package spmd_pkg;

  // Fixed field widths
  localparam int MASK_W   = 32;
  localparam int SIG_W    = 5;
  localparam int OP_W     = 3;
  localparam int ACT_W    = 3;
  localparam int CODE_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Number of signal slots; numbers at or above the limit are invalid
  localparam int NUM_SIGNALS = 32;
  localparam int SIG_LIMIT   = (NUM_SIGNALS < MASK_W) ? NUM_SIGNALS : MASK_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_BLOCK   = 3'd1;
  localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd2;
  localparam logic [OP_W-1:0] OP_SETMASK = 3'd3;
  localparam logic [OP_W-1:0] OP_DELIVER = 3'd4;
  localparam logic [OP_W-1:0] OP_READ    = 3'd5;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TERM = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_USER = 3'd4;

  // Status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_BAD_SIG = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM = 2'd2;

  // Signals with fixed behavior
  localparam logic [SIG_W-1:0] SIG_KILL = 5'd9;
  localparam logic [SIG_W-1:0] SIG_CONT = 5'd18;
  localparam logic [SIG_W-1:0] SIG_STOP = 5'd19;

  localparam logic [CODE_W-1:0] EXIT_BASE = 8'h80;

  localparam logic [MASK_W-1:0] UNMASKABLE =
      (MASK_W'(1) << SIG_KILL) | (MASK_W'(1) << SIG_STOP);

  typedef enum logic [2:0] {
    DEF_IGNORE = 3'd0,
    DEF_CONT   = 3'd1,
    DEF_STOP   = 3'd2,
    DEF_TERM   = 3'd3,
    DEF_CORE   = 3'd4
  } def_kind_t;

  // Default action of each signal number
  function automatic def_kind_t def_kind(input logic [SIG_W-1:0] n);
    def_kind_t k;
    unique case (n)
      5'd0, 5'd17, 5'd23, 5'd28:              k = DEF_IGNORE;
      5'd18:                                  k = DEF_CONT;
      5'd19, 5'd20, 5'd21, 5'd22:             k = DEF_STOP;
      5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
      5'd11, 5'd31:                           k = DEF_CORE;
      default:                                k = DEF_TERM;
    endcase
    return k;
  endfunction

  // Signals whose default action ends a delivery scan (terminate, core, stop)
  function automatic logic [MASK_W-1:0] def_end_mask_f();
    logic [MASK_W-1:0] m;
    def_kind_t k;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      k = def_kind(SIG_W'(i));
      m[i] = (k == DEF_TERM) || (k == DEF_CORE) || (k == DEF_STOP);
    end
    return m;
  endfunction

  // Deliverable signal numbers: 1 .. SIG_LIMIT-1
  function automatic logic [MASK_W-1:0] valid_sig_mask_f();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 1; i < SIG_LIMIT; i++) m[i] = 1'b1;
    return m;
  endfunction

  localparam logic [MASK_W-1:0] DEF_END_MASK   = def_end_mask_f();
  localparam logic [MASK_W-1:0] VALID_SIG_MASK = valid_sig_mask_f();

endpackage

// ===== rtl/spmd_req_if.sv =====
`timescale 1ns / 1ps
// Request channel for the signal pending mask dispatch block.
// Depends on spmd_pkg for field widths.
interface spmd_req_if;
  import spmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SIG_W-1:0]  signal_number;
  logic [MASK_W-1:0] mask_value;

  modport source (output valid, op, signal_number, mask_value, input ready);
  modport sink   (input valid, op, signal_number, mask_value, output ready);
endinterface

// ===== rtl/spmd_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel for the signal pending mask dispatch block.
// Depends on spmd_pkg for field widths.
interface spmd_rsp_if;
  import spmd_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [ACT_W-1:0]  action;
  logic [SIG_W-1:0]  action_signal;
  logic              core_dump;
  logic [CODE_W-1:0] exit_code;
  logic [MASK_W-1:0] blocked_before;
  logic [MASK_W-1:0] pending_now;
  logic              is_stopped;

  modport source (output valid, status, action, action_signal, core_dump, exit_code,
                  blocked_before, pending_now, is_stopped, input ready);
  modport sink   (input valid, status, action, action_signal, core_dump, exit_code,
                  blocked_before, pending_now, is_stopped, output ready);
endinterface

// ===== rtl/signal_pending_mask_dispatch_core.sv =====
`timescale 1ns / 1ps
// Signal pending mask dispatch: pending/blocked/stopped state and ordered delivery.
// Depends on spmd_pkg, spmd_req_if and spmd_rsp_if.
//
// Usage:
//   req  - request channel (valid/ready): op, signal_number, mask_value.
//   rsp  - result channel (valid/ready): one result per request.
//   cfg  - write port: cfg_wr_en, cfg_index (0 enable, 1 ignore mask,
//          2 custom mask), cfg_data. Write only while the block is idle.
// Path: a request is taken into the input register, then moves to the result
//   register, from which rsp shows it (one input register, one result register).
// Throughput: one request per cycle while rsp.ready stays high. Delivery is one
//   priority pick over the 32-bit eligible mask between the input and result
//   registers, and the state registers update in the same edge as the result register.
// Reset (rst, synchronous): masks, stopped flag, config and both stages clear.
// Stall: while rsp.ready is low the result register holds; the input register
//   still takes one more request, then req.ready drops until rsp drains.
module signal_pending_mask_dispatch_core (
  input  logic                              clk,
  input  logic                              rst,
  spmd_req_if.sink                          req,
  spmd_rsp_if.source                        rsp,
  input  logic                              cfg_wr_en,
  input  logic [spmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spmd_pkg::MASK_W-1:0]       cfg_data
);
  import spmd_pkg::*;

  // Configuration registers
  logic              enable;
  logic [MASK_W-1:0] ignore_mask;
  logic [MASK_W-1:0] custom_mask;

  // Architectural state
  logic [MASK_W-1:0] pending_set, pending_set_next;
  logic [MASK_W-1:0] blocked_set, blocked_set_next;
  logic              stopped_flag, stopped_flag_next;

  // Input stage
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [SIG_W-1:0]  s1_sig;
  logic [MASK_W-1:0] s1_mask;

  // Result stage
  logic              o_valid;
  logic              o_status;
  logic [ACT_W-1:0]  o_action;
  logic [SIG_W-1:0]  o_asig;
  logic              o_core;
  logic [CODE_W-1:0] o_code;
  logic [MASK_W-1:0] o_old;
  logic [MASK_W-1:0] o_pending;
  logic              o_stopped;

  // Combinational result of the item in the input stage
  logic              r_status;
  logic [ACT_W-1:0]  r_action;
  logic [SIG_W-1:0]  r_asig;
  logic              r_core;
  logic [CODE_W-1:0] r_code;

  logic s1_adv, out_free;

  // Delivery scan terms
  logic [MASK_W-1:0] ign_eff, cust_eff, ender, eligible, cand, first, span, cleared;
  logic [SIG_W-1:0]  first_idx;
  logic              cont_hit;
  def_kind_t         kind;
  logic [MASK_W-1:0] sig_bit;
  logic              sig_bad;

  // Handshake: result register frees when empty or taken
  assign out_free  = !o_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      ignore_mask <= '0;
      custom_mask <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE: enable      <= cfg_data[0];
        CFG_IGNORE: ignore_mask <= cfg_data;
        CFG_CUSTOM: custom_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op   <= req.op;
      s1_sig  <= req.signal_number;
      s1_mask <= req.mask_value;
    end
  end

  // Delivery scan: lowest eligible ender and all below it cleared (all eligible if none)
  always_comb begin
    ign_eff  = ignore_mask & ~UNMASKABLE;
    cust_eff = custom_mask & ~UNMASKABLE & ~ign_eff;
    ender    = cust_eff | (DEF_END_MASK & ~ign_eff);
    eligible = pending_set & ~blocked_set & VALID_SIG_MASK;
    cand     = eligible & ender;
    first    = cand & (~cand + MASK_W'(1));
    span     = (first == '0) ? '1 : (first | (first - MASK_W'(1)));
    cleared  = eligible & span;
    cont_hit = cleared[SIG_CONT] && !ign_eff[SIG_CONT] && !cust_eff[SIG_CONT];
    first_idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (first[i]) first_idx = first_idx | SIG_W'(i);
    end
    kind = def_kind(first_idx);
  end

  // Operation decode and state update
  always_comb begin
    pending_set_next  = pending_set;
    blocked_set_next  = blocked_set;
    stopped_flag_next = stopped_flag;
    r_status = STAT_OK;
    r_action = ACT_NONE;
    r_asig   = '0;
    r_core   = 1'b0;
    r_code   = '0;
    sig_bit  = MASK_W'(1) << s1_sig;
    sig_bad  = (s1_sig == '0) || ({1'b0, s1_sig} >= (SIG_W + 1)'(SIG_LIMIT));

    unique case (s1_op)
      OP_SEND: begin
        priority if (sig_bad) begin
          r_status = STAT_BAD_SIG;
        end else if (s1_sig == SIG_KILL) begin
          r_action = ACT_TERM;
          r_asig   = s1_sig;
          r_code   = EXIT_BASE | CODE_W'(s1_sig);
        end else if (s1_sig == SIG_STOP) begin
          stopped_flag_next = 1'b1;
          r_action = ACT_STOP;
          r_asig   = s1_sig;
        end else if (s1_sig == SIG_CONT) begin
          if (stopped_flag) begin
            stopped_flag_next = 1'b0;
            r_action = ACT_CONT;
            r_asig   = s1_sig;
          end
        end else if ((blocked_set & sig_bit) == '0) begin
          pending_set_next = pending_set | sig_bit;
        end
      end
      OP_BLOCK:   blocked_set_next = blocked_set | (s1_mask & ~UNMASKABLE);
      OP_UNBLOCK: blocked_set_next = blocked_set & ~s1_mask;
      OP_SETMASK: blocked_set_next = s1_mask & ~UNMASKABLE;
      OP_DELIVER: begin
        if (enable) begin
          pending_set_next = pending_set & ~cleared;
          // a default continue ahead of the end point resumes the process
          if (cont_hit && stopped_flag) begin
            stopped_flag_next = 1'b0;
            r_action = ACT_CONT;
            r_asig   = SIG_CONT;
          end
          if (first != '0) begin
            r_asig = first_idx;
            if (cust_eff[first_idx]) begin
              r_action = ACT_USER;
            end else if (kind == DEF_STOP) begin
              stopped_flag_next = 1'b1;
              r_action = ACT_STOP;
            end else begin
              r_action = ACT_TERM;
              r_core   = (kind == DEF_CORE);
              r_code   = EXIT_BASE | CODE_W'(first_idx);
            end
          end
        end
      end
      default: ;  // read and unused codes change nothing
    endcase
  end

  // State registers advance with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_set  <= '0;
      blocked_set  <= '0;
      stopped_flag <= 1'b0;
    end else if (s1_adv) begin
      pending_set  <= pending_set_next;
      blocked_set  <= blocked_set_next;
      stopped_flag <= stopped_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_status  <= r_status;
      o_action  <= r_action;
      o_asig    <= r_asig;
      o_core    <= r_core;
      o_code    <= r_code;
      o_old     <= blocked_set;
      o_pending <= pending_set_next;
      o_stopped <= stopped_flag_next;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.status         = o_status;
  assign rsp.action         = o_action;
  assign rsp.action_signal  = o_asig;
  assign rsp.core_dump      = o_core;
  assign rsp.exit_code      = o_code;
  assign rsp.blocked_before = o_old;
  assign rsp.pending_now    = o_pending;
  assign rsp.is_stopped     = o_stopped;

endmodule

// ===== rtl/spmd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the signal pending mask dispatch block, with its bind.
// Depends on spmd_pkg and signal_pending_mask_dispatch_core.
module spmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [spmd_pkg::ACT_W-1:0]    action,
  input logic [spmd_pkg::SIG_W-1:0]    action_signal,
  input logic                          core_dump,
  input logic [spmd_pkg::CODE_W-1:0]   exit_code,
  input logic [spmd_pkg::MASK_W-1:0]   pending_now,
  input logic                          is_stopped
);
  import spmd_pkg::*;

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pending_now) && $stable(action))
    else $error("stalled result changed");

  // No action means no signal, exit code or core flag
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && action == ACT_NONE |-> action_signal == '0 && exit_code == '0 && !core_dump)
    else $error("idle action carries data");

  // Stop leaves the process stopped; continue leaves it running
  a_stop_state: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (action == ACT_STOP || action == ACT_CONT) |->
      is_stopped == (action == ACT_STOP))
    else $error("stopped flag disagrees with action");

  // On terminate, the exit code matches the signal
  a_term_code: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && action == ACT_TERM |-> exit_code == (EXIT_BASE | CODE_W'(action_signal)))
    else $error("terminate exit code mismatch");

endmodule

bind signal_pending_mask_dispatch_core spmd_checker u_spmd_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .action        (rsp.action),
  .action_signal (rsp.action_signal),
  .core_dump     (rsp.core_dump),
  .exit_code     (rsp.exit_code),
  .pending_now   (rsp.pending_now),
  .is_stopped    (rsp.is_stopped)
);

// ===== sim/spmd_dispatch_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for signal_pending_mask_dispatch_core: tracks the register writes
// and requests, predicts each result and compares results in order.
// Depends on spmd_pkg, spmd_req_if and spmd_rsp_if.
module spmd_dispatch_checker
  import spmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  spmd_req_if                  req,
  spmd_rsp_if                  rsp,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct packed {
    logic              status;
    logic [ACT_W-1:0]  action;
    logic [SIG_W-1:0]  action_signal;
    logic              core_dump;
    logic [CODE_W-1:0] exit_code;
    logic [MASK_W-1:0] blocked_before;
    logic [MASK_W-1:0] pending_now;
    logic              is_stopped;
  } outcome_t;

  // Default disposition of each signal number
  localparam def_kind_t DEFAULT_KIND [32] = '{
    DEF_IGNORE, DEF_TERM,   DEF_TERM,   DEF_CORE,   DEF_CORE,   DEF_CORE,   DEF_CORE,
    DEF_CORE,   DEF_CORE,   DEF_TERM,   DEF_TERM,   DEF_CORE,   DEF_TERM,   DEF_TERM,
    DEF_TERM,   DEF_TERM,   DEF_TERM,   DEF_IGNORE, DEF_CONT,   DEF_STOP,   DEF_STOP,
    DEF_STOP,   DEF_STOP,   DEF_IGNORE, DEF_TERM,   DEF_TERM,   DEF_TERM,   DEF_TERM,
    DEF_IGNORE, DEF_TERM,   DEF_TERM,   DEF_CORE
  };

  // Shadow of the block's state and registers
  logic              deliver_en;
  logic [MASK_W-1:0] ignored_sigs;
  logic [MASK_W-1:0] handled_sigs;
  logic [MASK_W-1:0] pending_sigs;
  logic [MASK_W-1:0] blocked_sigs;
  logic              stopped;

  outcome_t expected_outcomes[$];
  outcome_t want, seen;
  int       reported;

  // Apply one request to the shadow state and return the result it must give
  function automatic outcome_t apply_request(input logic [OP_W-1:0]   op,
                                             input logic [SIG_W-1:0]  sig,
                                             input logic [MASK_W-1:0] operand);
    outcome_t r;
    int       n;
    logic     done;
    logic     fixed;
    r = '0;
    r.status = STAT_OK;
    r.action = ACT_NONE;
    r.blocked_before = blocked_sigs;
    done = 1'b0;
    case (op)
      OP_SEND: begin
        if (sig == '0 || int'(sig) >= SIG_LIMIT) begin
          r.status = STAT_BAD_SIG;
        end else if (sig == SIG_KILL) begin
          r.action = ACT_TERM;
          r.action_signal = sig;
          r.exit_code = EXIT_BASE + CODE_W'(sig);
        end else if (sig == SIG_STOP) begin
          stopped = 1'b1;
          r.action = ACT_STOP;
          r.action_signal = sig;
        end else if (sig == SIG_CONT) begin
          if (stopped) begin
            stopped = 1'b0;
            r.action = ACT_CONT;
            r.action_signal = sig;
          end
        end else if (!blocked_sigs[sig]) begin
          pending_sigs[sig] = 1'b1;
        end
      end
      OP_BLOCK:   blocked_sigs = blocked_sigs | (operand & ~UNMASKABLE);
      OP_UNBLOCK: blocked_sigs = blocked_sigs & ~operand;
      OP_SETMASK: blocked_sigs = operand & ~UNMASKABLE;
      OP_DELIVER: begin
        if (deliver_en) begin
          // ascending scan; ignored and continue signals do not stop it
          for (n = 1; n < SIG_LIMIT && !done; n++) begin
            if (!pending_sigs[n] || blocked_sigs[n]) continue;
            pending_sigs[n] = 1'b0;
            fixed = (n == int'(SIG_KILL)) || (n == int'(SIG_STOP));
            if (!fixed && ignored_sigs[n]) continue;
            if (!fixed && handled_sigs[n]) begin
              r.action = ACT_USER;
              r.action_signal = SIG_W'(n);
              done = 1'b1;
              continue;
            end
            case (DEFAULT_KIND[n])
              DEF_TERM, DEF_CORE: begin
                r.action = ACT_TERM;
                r.action_signal = SIG_W'(n);
                r.core_dump = (DEFAULT_KIND[n] == DEF_CORE);
                r.exit_code = EXIT_BASE + CODE_W'(n);
                done = 1'b1;
              end
              DEF_STOP: begin
                stopped = 1'b1;
                r.action = ACT_STOP;
                r.action_signal = SIG_W'(n);
                done = 1'b1;
              end
              DEF_CONT: begin
                if (stopped) begin
                  stopped = 1'b0;
                  r.action = ACT_CONT;
                  r.action_signal = SIG_W'(n);
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;  // read and unused codes change nothing
    endcase
    r.pending_now = pending_sigs;
    r.is_stopped = stopped;
    return r;
  endfunction

  function automatic string describe(input outcome_t o);
    return $sformatf("st=%0d act=%0d sig=%0d core=%0d code=%0d old=%h pend=%h stop=%0d",
                     o.status, o.action, o.action_signal, o.core_dump, o.exit_code,
                     o.blocked_before, o.pending_now, o.is_stopped);
  endfunction

  // Results are checked before the same edge's request is predicted
  always @(posedge clk) begin
    if (rst) begin
      deliver_en = 1'b0;
      ignored_sigs = '0;
      handled_sigs = '0;
      pending_sigs = '0;
      blocked_sigs = '0;
      stopped = 1'b0;
      expected_outcomes.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen.status = rsp.status;
        seen.action = rsp.action;
        seen.action_signal = rsp.action_signal;
        seen.core_dump = rsp.core_dump;
        seen.exit_code = rsp.exit_code;
        seen.blocked_before = rsp.blocked_before;
        seen.pending_now = rsp.pending_now;
        seen.is_stopped = rsp.is_stopped;
        if (expected_outcomes.size() == 0) begin
          fail_count++;
          if (reported < 10) $display("[%0t] unexpected result: %s", $realtime, describe(seen));
          reported++;
        end else begin
          want = expected_outcomes.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (reported < 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
            reported++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENABLE: deliver_en = cfg_data[0];
          CFG_IGNORE: ignored_sigs = cfg_data;
          CFG_CUSTOM: handled_sigs = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_outcomes.push_back(apply_request(req.op, req.signal_number, req.mask_value));
    end
    outstanding = expected_outcomes.size();
  end

endmodule

// ===== sim/signal_pending_mask_dispatch_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for signal_pending_mask_dispatch_core: clock, reset, request
// and result traffic with random idling, register writes and the verdict.
// Depends on spmd_pkg, spmd_req_if, spmd_rsp_if and spmd_dispatch_checker.
module signal_pending_mask_dispatch_core_tb;
  import spmd_pkg::*;

  localparam logic [OP_W-1:0]   OP_RSVD6    = 3'd6;
  localparam logic [OP_W-1:0]   OP_RSVD7    = 3'd7;
  localparam logic [MASK_W-1:0] ALL_ONES    = '1;
  localparam int                PHASES      = 12;
  localparam int                PHASE_ITEMS = 150;
  localparam int                HOLD_CYCLES = 64;
  localparam int                STALL_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MASK_W-1:0]    cfg_data;
  int                   fail_count;
  int                   outstanding;
  int                   idle_cycles;
  bit                   no_idle;
  bit                   hold_results;

  spmd_req_if req_ch ();
  spmd_rsp_if rsp_ch ();

  signal_pending_mask_dispatch_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spmd_dispatch_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 3));
  endfunction

  // Mostly sparse masks so that sends still land in the pending set
  function automatic logic [MASK_W-1:0] draw_mask();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return ALL_ONES;
    if (pick == 1) return '0;
    if (pick < 5) return $urandom;
    return $urandom & $urandom & $urandom;
  endfunction

  // Offer one request after a random gap; valid stays high into the next one
  task automatic send_request(input logic [OP_W-1:0] op, input logic [SIG_W-1:0] sig,
                              input logic [MASK_W-1:0] operand);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.signal_number <= sig;
    req_ch.mask_value <= operand;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every request has its result
  task automatic settle_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all three registers back to back; upper enable bits carry noise
  task automatic program_regs(input logic en, input logic [MASK_W-1:0] ign,
                              input logic [MASK_W-1:0] cust);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data <= {31'($urandom), en};
    @(posedge clk);
    cfg_index <= CFG_IGNORE;
    cfg_data <= ign;
    @(posedge clk);
    cfg_index <= CFG_CUSTOM;
    cfg_data <= cust;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random request: mostly sends and deliveries, some mask traffic and noise
  task automatic random_request();
    int               pick;
    logic [SIG_W-1:0] sig;
    pick = $urandom_range(0, 99);
    sig = ($urandom_range(0, 19) == 0) ? SIG_W'(0) : SIG_W'($urandom_range(1, 31));
    if (pick < 45)      send_request(OP_SEND, sig, $urandom);
    else if (pick < 70) send_request(OP_DELIVER, SIG_W'($urandom), $urandom);
    else if (pick < 77) send_request(OP_BLOCK, SIG_W'($urandom), draw_mask());
    else if (pick < 84) send_request(OP_UNBLOCK, SIG_W'($urandom), draw_mask());
    else if (pick < 90) send_request(OP_SETMASK, SIG_W'($urandom), draw_mask());
    else if (pick < 96) send_request(OP_READ, SIG_W'($urandom), $urandom);
    else if (pick < 98) send_request(OP_RSVD6, SIG_W'($urandom), $urandom);
    else                send_request(OP_RSVD7, SIG_W'($urandom), $urandom);
  endtask

  // Result side: random stalls, plus one long hold-off when asked
  initial begin : result_sink
    int stall;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_results) begin
        stall = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin : stimulus
    int                p;
    int                k;
    logic              en;
    logic [MASK_W-1:0] ign;
    logic [MASK_W-1:0] cust;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_READ;
    req_ch.signal_number = '0;
    req_ch.mask_value = '0;
    no_idle = 1'b0;
    hold_results = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: delivery still disabled after reset
    send_request(OP_SEND, SIG_W'(0), '0);           // invalid signal number
    send_request(OP_SEND, SIG_W'(2), '0);
    send_request(OP_DELIVER, '0, '0);               // disabled, nothing changes
    send_request(OP_READ, SIG_W'(31), ALL_ONES);
    send_request(OP_RSVD6, SIG_W'(31), ALL_ONES);
    send_request(OP_RSVD7, SIG_W'(31), ALL_ONES);
    settle_results();
    program_regs(1'b1, '0, '0);

    // Directed: kill/stop/continue, masks at the extremes, ordered delivery
    send_request(OP_SETMASK, '0, ALL_ONES);         // kill and stop stay unblocked
    send_request(OP_SEND, SIG_KILL, '0);
    send_request(OP_SEND, SIG_W'(4), '0);           // blocked, not pending
    send_request(OP_SEND, SIG_STOP, '0);
    send_request(OP_SEND, SIG_CONT, '0);            // resumes
    send_request(OP_SEND, SIG_CONT, '0);            // not stopped: no action
    send_request(OP_UNBLOCK, '0, ALL_ONES);
    send_request(OP_SEND, SIG_W'(17), '0);
    send_request(OP_SEND, SIG_W'(3), '0);
    send_request(OP_SEND, SIG_W'(31), '0);
    send_request(OP_SEND, SIG_W'(20), '0);
    send_request(OP_DELIVER, '0, '0);               // 2 terminates
    send_request(OP_DELIVER, '0, '0);               // 3 with core dump
    send_request(OP_DELIVER, '0, '0);               // 17 skipped, 20 stops
    send_request(OP_DELIVER, '0, '0);               // 31 with core dump
    send_request(OP_DELIVER, '0, '0);               // nothing left
    settle_results();
    program_regs(1'b1, 32'h0000_0010, 32'h0020_0210);
    send_request(OP_SEND, SIG_W'(4), '0);
    send_request(OP_SEND, SIG_W'(21), '0);
    send_request(OP_DELIVER, '0, '0);               // 4 ignored, 21 to user handler
    settle_results();

    // Random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      en = ($urandom_range(0, 7) != 0);
      ign = draw_mask();
      cust = draw_mask();
      case (p)
        0: begin en = 1'b1; ign = '0;       cust = '0;       end
        1: begin en = 1'b1; ign = ALL_ONES; cust = '0;       end
        2: begin en = 1'b1; ign = '0;       cust = ALL_ONES; end
        3: en = 1'b0;
        4: begin en = 1'b1; ign = ALL_ONES; cust = ALL_ONES; end
        default: ;
      endcase
      no_idle = (p == 2 || p == 7);
      program_regs(en, ign, cust);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ((p == 5 || p == 9) && k == 20) hold_results = 1'b1;
        random_request();
      end
      settle_results();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
